[rtl/aspt_pkg.sv]
// aspt_pkg: shared types and constants for the angular separation point thinning block
// no dependencies; used by the interfaces, the top level and the checker
package aspt_pkg;

  localparam int MAX_KEPT = 64;
  localparam int KEPT_AW  = $clog2(MAX_KEPT);
  localparam int CNT_W    = KEPT_AW + 1;
  localparam int WANTED_W = 7;
  localparam int CMP_W    = (CNT_W > WANTED_W) ? CNT_W : WANTED_W;
  localparam int COORD_W  = 16;
  localparam int FRAC_W   = 14;
  localparam int PROD_W   = 2 * COORD_W;
  localparam int DOT_W    = PROD_W + 2;
  localparam int LIMIT_W  = COORD_W + FRAC_W;
  localparam int ENTRY_W  = 3 * COORD_W;
  localparam int ADDR_W   = 3;
  localparam int DATA_W   = 32;

  typedef logic signed [COORD_W-1:0] coord_t;

  // register index, taken from paddr[2]
  typedef enum logic {
    REG_WANTED = 1'b0,
    REG_COS    = 1'b1
  } reg_idx_t;

  localparam coord_t COS_RESET = coord_t'(16384);

endpackage

[rtl/aspt_if.sv]
// aspt_in_if / aspt_out_if: valid-ready channels for points and keep marks
// depends on aspt_pkg
interface aspt_in_if import aspt_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t pos_x;
  coord_t pos_y;
  coord_t pos_z;
  logic   batch_end;

  modport source (output valid, output pos_x, output pos_y, output pos_z,
                  output batch_end, input ready);
  modport sink   (input valid, input pos_x, input pos_y, input pos_z,
                  input batch_end, output ready);
endinterface

interface aspt_out_if import aspt_pkg::*; ();
  logic valid;
  logic ready;
  logic keep_mark;
  logic batch_end_out;

  modport source (output valid, output keep_mark, output batch_end_out, input ready);
  modport sink   (input valid, input keep_mark, input batch_end_out, output ready);
endinterface

[rtl/angular_separation_point_thinning.sv]
// angular_separation_point_thinning: greedy min-separation thinning of unit vectors
// depends on aspt_pkg and the aspt_in_if / aspt_out_if channels
// per item: between item accept and result valid the sequencer scans j kept points
//   (at most the points kept so far in the batch, 0..63; a too-close point ends the scan
//   early); each scanned point costs one memory read and four multiply steps, and a
//   finished result waits in S_DONE until the output register is free
// throughput: one item at a time; the next item is taken the cycle after the result
//   register is loaded, and while that result still waits on the output
// reset (rst, synchronous): wanted_count 0, cos_threshold 1.0, kept list and index empty
module angular_separation_point_thinning import aspt_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  aspt_in_if.sink             in_ch,
  aspt_out_if.source          out_ch,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [DATA_W-1:0]   pwdata,
  output logic [DATA_W-1:0]   prdata,
  output logic                pready
);

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_READ = 4'b0010,
    S_MUL  = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t state;

  // configuration registers
  logic [WANTED_W-1:0] wanted_count;
  coord_t              cos_threshold;

  // batch state
  logic [CNT_W-1:0] kept_count;
  logic [CNT_W-1:0] point_index;

  // latched item and per-item working registers
  coord_t              px, py, pz;
  logic                last_r;
  logic                keep_r;
  logic [KEPT_AW-1:0]  k;
  logic [1:0]          comp;
  logic signed [PROD_W-1:0] prod;
  logic signed [DOT_W-1:0]  acc;

  // kept point memory, one entry holds x, y, z
  logic [ENTRY_W-1:0] kept_mem [MAX_KEPT];
  logic [ENTRY_W-1:0] rd_data;
  logic               mem_we;

  // output register
  logic out_valid;
  logic out_keep;
  logic out_last;

  logic                     cfg_wr;
  logic                     cand;
  logic                     out_free;
  logic signed [LIMIT_W-1:0] limit;
  logic signed [DOT_W-1:0]  dot_sum;
  coord_t                   mul_a;
  coord_t                   mul_b;
  logic [CNT_W-1:0]         k_next;

  // ---------------------------------------------------------------------------
  // configuration port: write on the access phase, reads are combinational
  // ---------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wanted_count  <= '0;
      cos_threshold <= COS_RESET;
    end else if (cfg_wr) begin
      unique case (reg_idx_t'(paddr[2]))
        REG_WANTED: wanted_count  <= pwdata[WANTED_W-1:0];
        REG_COS:    cos_threshold <= pwdata[COORD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx_t'(paddr[2]))
      REG_WANTED: prdata = DATA_W'(wanted_count);
      REG_COS:    prdata = DATA_W'(cos_threshold);
      default:    prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // candidate test: inside the first wanted_count points and below capacity
  // ---------------------------------------------------------------------------
  assign cand = (point_index < CNT_W'(MAX_KEPT))
             && (CMP_W'(point_index) < CMP_W'(wanted_count));

  // threshold scaled to Q2.28
  assign limit = {cos_threshold, {FRAC_W{1'b0}}};

  // shared multiplier operands: component comp of the point and of the kept entry
  always_comb begin
    unique case (comp)
      2'd0:    begin mul_a = px; mul_b = rd_data[3*COORD_W-1:2*COORD_W]; end
      2'd1:    begin mul_a = py; mul_b = rd_data[2*COORD_W-1:COORD_W];   end
      default: begin mul_a = pz; mul_b = rd_data[COORD_W-1:0];           end
    endcase
  end

  // final sum on the last step, compared in the same cycle
  assign dot_sum  = acc + DOT_W'(prod);
  assign k_next   = CNT_W'(k) + CNT_W'(1);
  assign out_free = !out_valid || out_ch.ready;

  assign in_ch.ready = (state == S_IDLE);

  // ---------------------------------------------------------------------------
  // sequencer: one kept point per pass, read then three products and a compare
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      kept_count  <= '0;
      point_index <= '0;
      out_valid   <= 1'b0;
    end else begin
      // load a new result, or drop the one just taken
      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ch.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_ch.valid) begin
            px     <= in_ch.pos_x;
            py     <= in_ch.pos_y;
            pz     <= in_ch.pos_z;
            last_r <= in_ch.batch_end;
            k      <= '0;
            priority if (!cand) begin
              keep_r <= 1'b0;
              state  <= S_DONE;
            end else if (kept_count == '0) begin
              // first candidate of a batch is always kept
              keep_r <= 1'b1;
              state  <= S_DONE;
            end else begin
              state <= S_READ;
            end
          end
        end
        S_READ: begin
          // read data for entry k lands in rd_data this edge
          comp  <= 2'd0;
          state <= S_MUL;
        end
        S_MUL: begin
          prod <= mul_a * mul_b;
          comp <= comp + 2'd1;
          if (comp == 2'd0) begin
            acc <= '0;
          end else begin
            acc <= dot_sum;
          end
          if (comp == 2'd3) begin
            priority if (!(dot_sum < DOT_W'(limit))) begin
              // too close to a kept point
              keep_r <= 1'b0;
              state  <= S_DONE;
            end else if (k_next == kept_count) begin
              keep_r <= (kept_count < CNT_W'(MAX_KEPT));
              state  <= S_DONE;
            end else begin
              k     <= k + KEPT_AW'(1);
              state <= S_READ;
            end
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_keep  <= keep_r;
            out_last  <= last_r;
            priority if (last_r) begin
              kept_count  <= '0;
              point_index <= '0;
            end else begin
              if (keep_r) begin
                kept_count <= kept_count + CNT_W'(1);
              end
              if (point_index < CNT_W'(MAX_KEPT)) begin
                point_index <= point_index + CNT_W'(1);
              end
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // store the kept point when its result is committed
  assign mem_we = (state == S_DONE) && out_free && keep_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      kept_mem[kept_count[KEPT_AW-1:0]] <= {px, py, pz};
    end
    rd_data <= kept_mem[k];
  end

  assign out_ch.valid         = out_valid;
  assign out_ch.keep_mark     = out_keep;
  assign out_ch.batch_end_out = out_last;

endmodule

[rtl/aspt_checker.sv]
// aspt_checker: port-level assertions for angular_separation_point_thinning
// depends on aspt_pkg; bound to the top level at the end of this file
module aspt_checker import aspt_pkg::*; (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_keep,
  input logic out_last
);

  // an accepted item occupies the block for at least the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("ready stayed high after an item was accepted");

  // no result shows right out of reset
  a_reset_clean: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result valid right after reset");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_keep) && $stable(out_last))
    else $error("stalled result changed");

  // no result can come the cycle after an accept with an empty output
  a_no_instant_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !out_valid |=> !out_valid)
    else $error("result appeared too early");

endmodule

bind angular_separation_point_thinning aspt_checker u_aspt_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_keep  (out_ch.keep_mark),
  .out_last  (out_ch.batch_end_out)
);

[tb/angular_separation_point_thinning_tb.sv]
// testbench for angular_separation_point_thinning: drives batches of points, checks keep marks
// depends on aspt_pkg, aspt_in_if / aspt_out_if and the rtl top level
// self-checking against an in-bench greedy thinning predictor, apb config, random idling
module angular_separation_point_thinning_tb;
  import aspt_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // expectation source of a stimulus row: predictor, or typed in as kept / dropped
  typedef enum logic [1:0] {
    EXP_PRED,
    EXP_KEEP,
    EXP_DROP
  } exp_kind_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
    logic   last;
  } point_t;

  typedef struct packed {
    logic keep;
    logic last;
  } mark_t;

  // one directed row: optional register setting taken before the point, then the point
  typedef struct packed {
    logic                cfg;
    logic [WANTED_W-1:0] wanted;
    coord_t              cos;
    coord_t              x;
    coord_t              y;
    coord_t              z;
    logic                last;
    exp_kind_t           ek;
  } dir_row_t;

  localparam int N_DIR        = 22;
  localparam int RAND_ITEMS   = 2000;
  localparam int PHASE_ITEMS  = 150;
  localparam int HOLD_CYCLES  = 300;
  localparam int SETTLE_CYC   = 8;
  localparam int TAIL_CYC     = 400;   // longer than a full scan of 63 kept points
  localparam int DRAIN_LIMIT  = 200000;

  // handy Q1.14 values for the table
  localparam coord_t ONE  = 16'sd16384;
  localparam coord_t NONE = -16'sd16384;
  localparam coord_t MINV = 16'h8000;
  localparam coord_t MAXV = 16'h7fff;
  localparam coord_t ZERO = 16'sd0;

  logic clk = 1'b0;
  logic rst;

  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  aspt_in_if  in_ch ();
  aspt_out_if out_ch ();

  angular_separation_point_thinning dut (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #1 clk = ~clk;

  // ---------------------------------------------------------------------------
  // predictor state: the registers as last written plus the kept list of the
  // batch in progress
  // ---------------------------------------------------------------------------
  logic [WANTED_W-1:0] wanted_cfg = '0;
  coord_t              cos_cfg    = COS_RESET;
  coord_t              kept_x [MAX_KEPT];
  coord_t              kept_y [MAX_KEPT];
  coord_t              kept_z [MAX_KEPT];
  logic [CNT_W-1:0]    kept_n   = '0;
  logic [CNT_W-1:0]    pt_index = '0;

  mark_t mark_q [$];   // keep marks still owed by the block, oldest first
  int    fail_cnt = 0;
  int    sent_cnt = 0;

  // idling controls, set per phase by the stimulus
  int src_idle_pct  = 0;
  int snk_stall_pct = 0;
  int hold_req      = 0;   // bumped to ask the receiver for one long hold-off

  // greedy thinning step for one accepted point; returns its keep mark
  function automatic logic thin_predict(input point_t p);
    coord_t                  px;
    coord_t                  py;
    coord_t                  pz;
    logic signed [DOT_W-1:0] dot;
    logic signed [DOT_W-1:0] lim;
    logic                    far;
    logic                    keep;
    px   = p.x;
    py   = p.y;
    pz   = p.z;
    keep = 1'b0;
    // candidate only while within both the wanted count and the list capacity
    if (pt_index < MAX_KEPT && pt_index < wanted_cfg) begin
      far = 1'b1;
      lim = DOT_W'(cos_cfg) <<< FRAC_W;   // threshold moved to Q2.28
      for (int k = 0; k < int'(kept_n); k++) begin
        dot = DOT_W'(px) * DOT_W'(kept_x[k]) + DOT_W'(py) * DOT_W'(kept_y[k])
            + DOT_W'(pz) * DOT_W'(kept_z[k]);
        if (!(dot < lim)) far = 1'b0;
      end
      if (far && kept_n < MAX_KEPT) begin
        kept_x[kept_n[KEPT_AW-1:0]] = px;
        kept_y[kept_n[KEPT_AW-1:0]] = py;
        kept_z[kept_n[KEPT_AW-1:0]] = pz;
        kept_n++;
        keep = 1'b1;
      end
    end
    // index saturates so that long batches stop producing candidates
    if (pt_index < MAX_KEPT) pt_index++;
    if (p.last) begin
      kept_n   = '0;
      pt_index = '0;
    end
    return keep;
  endfunction

  // ---------------------------------------------------------------------------
  // directed table: reset state, register extremes, exact-threshold ties,
  // out-of-range vectors, count above capacity, count of one and zero count
  // ---------------------------------------------------------------------------
  dir_row_t dir_rows [0:N_DIR-1] = '{
    // after reset the wanted count is zero, so nothing is kept
    '{1'b0, 7'd0,   ZERO, ONE,  ZERO, ZERO, 1'b1, EXP_DROP},
    // cos 1.0: first point kept, a repeat ties the threshold and is dropped
    '{1'b1, 7'd64,  ONE,  ONE,  ZERO, ZERO, 1'b0, EXP_KEEP},
    '{1'b0, 7'd0,   ZERO, ONE,  ZERO, ZERO, 1'b0, EXP_DROP},
    '{1'b0, 7'd0,   ZERO, ZERO, ONE,  ZERO, 1'b0, EXP_KEEP},
    '{1'b0, 7'd0,   ZERO, NONE, ZERO, ZERO, 1'b0, EXP_KEEP},
    // out-of-range vectors: most negative and most positive patterns
    '{1'b0, 7'd0,   ZERO, MINV, MINV, MINV, 1'b0, EXP_PRED},
    '{1'b0, 7'd0,   ZERO, MAXV, MAXV, MAXV, 1'b1, EXP_DROP},
    // count above capacity, cos -1.0: antipode ties, doubled antipode passes
    '{1'b1, 7'd127, NONE, ZERO, ZERO, ONE,  1'b0, EXP_KEEP},
    '{1'b0, 7'd0,   ZERO, ZERO, ZERO, NONE, 1'b0, EXP_DROP},
    '{1'b0, 7'd0,   ZERO, ZERO, ZERO, MINV, 1'b1, EXP_KEEP},
    // wanted count one: only the first point of the batch is a candidate
    '{1'b1, 7'd1,   ZERO, ZERO, ONE,  ZERO, 1'b0, EXP_KEEP},
    '{1'b0, 7'd0,   ZERO, ONE,  ZERO, ZERO, 1'b0, EXP_DROP},
    '{1'b0, 7'd0,   ZERO, NONE, ZERO, ZERO, 1'b1, EXP_DROP},
    // cos 0: orthogonal points tie and are dropped
    '{1'b1, 7'd64,  ZERO, ONE,  ZERO, ZERO, 1'b0, EXP_KEEP},
    '{1'b0, 7'd0,   ZERO, ZERO, ONE,  ZERO, 1'b0, EXP_DROP},
    '{1'b0, 7'd0,   ZERO, NONE, ZERO, ZERO, 1'b0, EXP_KEEP},
    '{1'b0, 7'd0,   ZERO, ZERO, ZERO, ONE,  1'b1, EXP_DROP},
    // threshold register extremes beyond the Q1.14 unit range
    '{1'b1, 7'd64,  MINV, 16'sd1, 16'sd1, 16'sd1, 1'b0, EXP_KEEP},
    '{1'b0, 7'd0,   ZERO, MINV, MINV, MINV, 1'b1, EXP_PRED},
    '{1'b1, 7'd64,  MAXV, ZERO, ZERO, ZERO, 1'b0, EXP_KEEP},
    '{1'b0, 7'd0,   ZERO, ZERO, ZERO, ZERO, 1'b1, EXP_KEEP},
    // zero count written explicitly
    '{1'b1, 7'd0,   ONE,  ONE,  ONE,  ONE,  1'b1, EXP_DROP}
  };

  // apb write: setup phase, then access phase, then idle with psel low
  task automatic reg_write(input reg_idx_t idx, input logic [DATA_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      REG_WANTED: wanted_cfg = val[WANTED_W-1:0];
      REG_COS:    cos_cfg    = coord_t'(val[COORD_W-1:0]);
    endcase
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // offer one item, optionally after a random gap; returns at the accepting edge
  task automatic send_point(input point_t p, input exp_kind_t ek);
    mark_t m;
    while (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.pos_x     <= p.x;
    in_ch.pos_y     <= p.y;
    in_ch.pos_z     <= p.z;
    in_ch.batch_end <= p.last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    // predictor always advances; typed rows override its mark
    m.keep = thin_predict(p);
    if (ek == EXP_KEEP) m.keep = 1'b1;
    else if (ek == EXP_DROP) m.keep = 1'b0;
    m.last = p.last;
    mark_q.insert(mark_q.size(), m);
    sent_cnt++;
  endtask

  // wait until every owed mark is back so the registers may be rewritten
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (mark_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  // one batch of random points, closed by batch_end
  task automatic run_batch();
    point_t pts [$];
    point_t p;
    int     len;
    int     pick;
    real    ax;
    real    ay;
    real    az;
    real    nrm;
    coord_t v;
    pick = $urandom_range(0, 99);
    if (pick < 90) len = $urandom_range(1, 16);
    else if (pick < 97) len = $urandom_range(17, 40);
    else len = $urandom_range(MAX_KEPT, MAX_KEPT + 8);   // runs past the saturated index
    for (int j = 0; j < len; j++) begin
      pick = $urandom_range(0, 99);
      p    = '0;
      if (pick < 84) begin
        // random direction scaled to unit length in Q1.14
        ax  = $itor($urandom_range(0, 2000)) - 1000.0;
        ay  = $itor($urandom_range(0, 2000)) - 1000.0;
        az  = $itor($urandom_range(0, 2000)) - 1000.0;
        nrm = $sqrt(ax * ax + ay * ay + az * az);
        if (nrm < 1.0) begin
          p.x = ONE;
        end else begin
          p.x = coord_t'($rtoi(ax * 16384.0 / nrm));
          p.y = coord_t'($rtoi(ay * 16384.0 / nrm));
          p.z = coord_t'($rtoi(az * 16384.0 / nrm));
        end
      end else if (pick < 90) begin
        // axis points give exact ties at cos 0 and 1.0
        v = $urandom_range(0, 1) ? ONE : NONE;
        case ($urandom_range(0, 2))
          0:       p.x = v;
          1:       p.y = v;
          default: p.z = v;
        endcase
      end else if (pick < 95 && pts.size() != 0) begin
        p = pts[$urandom_range(0, pts.size() - 1)];
      end else begin
        // raw patterns outside the unit sphere
        p.x = coord_t'($urandom);
        p.y = coord_t'($urandom);
        p.z = coord_t'($urandom);
      end
      p.last = (j == len - 1);
      pts.insert(pts.size(), p);
      send_point(p, EXP_PRED);
    end
  endtask

  // ---------------------------------------------------------------------------
  // receiver: random stalls per phase, plus one long hold-off on request so
  // the block fills up and pushes back on its input
  // ---------------------------------------------------------------------------
  int hold_seen = 0;
  int hold_left = 0;

  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= snk_stall_pct);
    end
  end

  // result checker: every accepted mark against the oldest expectation
  always @(posedge clk) begin
    mark_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (mark_q.size() == 0) begin
        $display("%0t: unexpected item, expected none, got keep_mark %0b batch_end_out %0b",
                 $time, out_ch.keep_mark, out_ch.batch_end_out);
        fail_cnt++;
      end else begin
        want = mark_q.pop_front();
        if (out_ch.keep_mark !== want.keep) begin
          $display("%0t: keep_mark mismatch, expected %0b, got %0b",
                   $time, want.keep, out_ch.keep_mark);
          fail_cnt++;
        end
        if (out_ch.batch_end_out !== want.last) begin
          $display("%0t: batch_end_out mismatch, expected %0b, got %0b",
                   $time, want.last, out_ch.batch_end_out);
          fail_cnt++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // main sequence: reset, directed table, random phases, drain
  // ---------------------------------------------------------------------------
  initial begin
    point_t p;
    int     phase;
    int     phase_start;
    int     drain;
    logic [WANTED_W-1:0] w;
    coord_t c;

    rst             <= 1'b1;
    psel            <= 1'b0;
    penable         <= 1'b0;
    pwrite          <= 1'b0;
    paddr           <= '0;
    pwdata          <= '0;
    in_ch.valid     <= 1'b0;
    in_ch.pos_x     <= '0;
    in_ch.pos_y     <= '0;
    in_ch.pos_z     <= '0;
    in_ch.batch_end <= 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed rows, no idling on the input side
    for (int i = 0; i < N_DIR; i++) begin
      if (dir_rows[i].cfg) begin
        settle();
        reg_write(REG_WANTED, DATA_W'(dir_rows[i].wanted));
        reg_write(REG_COS, DATA_W'(dir_rows[i].cos));
      end
      p.x    = dir_rows[i].x;
      p.y    = dir_rows[i].y;
      p.z    = dir_rows[i].z;
      p.last = dir_rows[i].last;
      send_point(p, dir_rows[i].ek);
    end

    // random phases: new registers and a new idling pattern each time
    phase = 0;
    while (sent_cnt < N_DIR + RAND_ITEMS) begin
      settle();
      case ($urandom_range(0, 7))
        0:       w = '0;
        1:       w = WANTED_W'(MAX_KEPT);
        2:       w = '1;   // above capacity
        3:       w = WANTED_W'(1);
        default: w = WANTED_W'($urandom_range(2, 20));
      endcase
      case ($urandom_range(0, 7))
        0:       c = ONE;
        1:       c = NONE;
        2:       c = coord_t'($urandom);
        3:       c = ZERO;
        default: c = coord_t'($urandom_range(6000, 16000));   // small separation angles
      endcase
      reg_write(REG_WANTED, DATA_W'(w));
      reg_write(REG_COS, DATA_W'(c));
      case (phase % 4)
        0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1: begin src_idle_pct = 58; snk_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  snk_stall_pct = 58; end
        default: begin src_idle_pct = 23; snk_stall_pct = 23; end
      endcase
      // one phase with a long receiver hold while items keep coming
      if (phase == 4) hold_req++;
      phase_start = sent_cnt;
      while (sent_cnt - phase_start < PHASE_ITEMS) run_batch();
      phase++;
    end

    in_ch.valid <= 1'b0;
    drain = 0;
    while (mark_q.size() != 0 && drain < DRAIN_LIMIT) begin
      @(posedge clk);
      drain++;
    end
    repeat (TAIL_CYC) @(posedge clk);
    if (mark_q.size() != 0)
      $display("%0t: %0d expected items never arrived", $time, mark_q.size());
    if (fail_cnt == 0 && mark_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // hang guard, far above the slowest correct run
  initial begin
    #10_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule

[filelist.f]
rtl/aspt_pkg.sv
rtl/aspt_if.sv
rtl/angular_separation_point_thinning.sv
rtl/aspt_checker.sv
tb/angular_separation_point_thinning_tb.sv
